// File: hdl/framed_packet_parser_crc16_core_assert.svh
// Assertion macros used by the deframer's checker file.
`ifndef FRAMED_PACKET_PARSER_CRC16_CORE_ASSERT_SVH
`define FRAMED_PACKET_PARSER_CRC16_CORE_ASSERT_SVH

// Implication in the same cycle, switched off while reset is asserted.
`define FPPC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle, switched off while reset is asserted.
`define FPPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the following cycle that is also checked during reset.
`define FPPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/fppc_pkg.sv
// Types, constants and the CRC byte update shared by the packet deframer.
package fppc_pkg;

    localparam int CFG_ADDR_W = 4;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_VER     = 4'd1,
        PH_TYPE    = 4'd2,
        PH_LEN_L   = 4'd3,
        PH_LEN_H   = 4'd4,
        PH_STAMP   = 4'd5,
        PH_FRAME   = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CRC_L   = 4'd8,
        PH_CRC_H   = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_CRC_ERR = 3'd3,
        KIND_DESYNC  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_START   = 2'd0,
        REG_VERSION = 2'd1,
        REG_LIMIT   = 2'd2
    } cfg_idx_t;

    localparam logic [7:0]  START_RESET   = 8'd165;
    localparam logic [7:0]  VERSION_RESET = 8'd1;
    localparam logic [10:0] LIMIT_RESET   = 11'd1024;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [10:0] FIELD_BYTES = 11'd4;

    // CRC-16/CCITT-FALSE over one byte, most significant bit first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/framed_packet_parser_crc16_core.sv
// Top level of the framed packet deframer with CRC-16 check.
// Byte-stream deframer: each input transfer carries one received byte and produces exactly one
// result transfer. The block hunts for the start byte, checks the version byte, then collects
// type, little-endian length, time stamp, frame number, payload and CRC (CRC-16/CCITT-FALSE
// over everything after the start byte). Payload bytes come out as they arrive; the last CRC
// byte reports good or CRC error, and a wrong version or an over-long length reports desync.
// Sustained rate is one byte per clock while m_ready stays high. The byte sits in the input
// register, and the combinational byte-wide CRC and parser update loads the result register
// from it. The header, length and counter fields of a result show the parser state just after
// that byte. Registers over APB: 0x0 start byte, 0x4 version byte, 0x8 payload limit.
module framed_packet_parser_crc16_core #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fppc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_kind,
    output logic [7:0]                      m_data_byte,
    output logic [9:0]                      m_payload_index,
    output logic [7:0]                      m_packet_type,
    output logic [10:0]                     m_packet_length,
    output logic [31:0]                     m_time_stamp,
    output logic [31:0]                     m_frame_number,
    output logic [31:0]                     m_good_count,
    output logic [31:0]                     m_crc_error_count,
    output logic [31:0]                     m_desync_count
);
    import fppc_pkg::*;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [7:0]  start_reg;
    logic [7:0]  version_reg;
    logic [10:0] limit_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [10:0] pos_reg, pos_next;
    logic [7:0]  type_reg, type_next;
    logic [10:0] length_reg, length_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] frame_reg, frame_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] crc_err_reg, crc_err_next;
    logic [31:0] desync_reg, desync_next;

    logic        m_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [9:0]  index_reg, index_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] limit_eff;
    logic [10:0] pos_inc;
    logic [4:0]  lane_shift;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= START_RESET;
            version_reg <= VERSION_RESET;
            limit_reg   <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_START:   start_reg   <= pwdata[7:0];
                REG_VERSION: version_reg <= pwdata[7:0];
                REG_LIMIT:   limit_reg   <= pwdata[10:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START:   prdata = {24'd0, start_reg};
            REG_VERSION: prdata = {24'd0, version_reg};
            REG_LIMIT:   prdata = {21'd0, limit_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Input register; the parser advances whenever the result register is free or emptying.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Parser datapath
    assign crc_upd    = crc16_byte(crc_reg, in_byte_reg);
    assign len_full   = {in_byte_reg, length_reg[7:0]};
    assign limit_eff  = ({5'd0, limit_reg} > MAX_LEN) ? MAX_LEN : {5'd0, limit_reg};
    assign pos_inc    = pos_reg + 11'd1;
    assign lane_shift = {pos_reg[1:0], 3'b000};

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        pos_next     = pos_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        stamp_next   = stamp_reg;
        frame_next   = frame_reg;
        crc_low_next = crc_low_reg;
        good_next    = good_reg;
        crc_err_next = crc_err_reg;
        desync_next  = desync_reg;
        kind_next    = KIND_NONE;
        data_next    = 8'd0;
        index_next   = 10'd0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (in_byte_reg == start_reg) begin
                    crc_next   = CRC_INIT;
                    phase_next = PH_VER;
                end
            end
            PH_VER: begin
                crc_next = crc_upd;
                if (in_byte_reg != version_reg) begin
                    phase_next  = PH_HUNT;
                    desync_next = desync_reg + 32'd1;
                    kind_next   = KIND_DESYNC;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                crc_next   = crc_upd;
                type_next  = in_byte_reg;
                phase_next = PH_LEN_L;
            end
            PH_LEN_L: begin
                crc_next    = crc_upd;
                length_next = {3'd0, in_byte_reg};
                phase_next  = PH_LEN_H;
            end
            PH_LEN_H: begin
                crc_next    = crc_upd;
                length_next = len_full[10:0];
                if (len_full > limit_eff) begin
                    phase_next  = PH_HUNT;
                    desync_next = desync_reg + 32'd1;
                    kind_next   = KIND_DESYNC;
                end else begin
                    pos_next   = 11'd0;
                    stamp_next = 32'd0;
                    phase_next = PH_STAMP;
                end
            end
            PH_STAMP: begin
                crc_next   = crc_upd;
                stamp_next = stamp_reg | ({24'd0, in_byte_reg} << lane_shift);
                pos_next   = pos_inc;
                if (pos_inc >= FIELD_BYTES) begin
                    pos_next   = 11'd0;
                    frame_next = 32'd0;
                    phase_next = PH_FRAME;
                end
            end
            PH_FRAME: begin
                crc_next   = crc_upd;
                frame_next = frame_reg | ({24'd0, in_byte_reg} << lane_shift);
                pos_next   = pos_inc;
                if (pos_inc >= FIELD_BYTES) begin
                    pos_next   = 11'd0;
                    phase_next = (length_reg == 11'd0) ? PH_CRC_L : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                crc_next   = crc_upd;
                kind_next  = KIND_PAYLOAD;
                data_next  = in_byte_reg;
                index_next = pos_reg[9:0];
                pos_next   = pos_inc;
                if (pos_inc >= length_reg) begin
                    phase_next = PH_CRC_L;
                end
            end
            PH_CRC_L: begin
                crc_low_next = in_byte_reg;
                phase_next   = PH_CRC_H;
            end
            PH_CRC_H: begin
                phase_next = PH_HUNT;
                if ({in_byte_reg, crc_low_reg} == crc_reg) begin
                    good_next = good_reg + 32'd1;
                    kind_next = KIND_GOOD;
                end else begin
                    crc_err_next = crc_err_reg + 32'd1;
                    kind_next    = KIND_CRC_ERR;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // The parser state only moves when a new result is loaded, so the header and counter
    // fields of the result are read straight from it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= CRC_INIT;
            pos_reg     <= 11'd0;
            type_reg    <= 8'd0;
            length_reg  <= 11'd0;
            stamp_reg   <= 32'd0;
            frame_reg   <= 32'd0;
            crc_low_reg <= 8'd0;
            good_reg    <= 32'd0;
            crc_err_reg <= 32'd0;
            desync_reg  <= 32'd0;
            m_valid_reg <= 1'b0;
            kind_reg    <= KIND_NONE;
            data_reg    <= 8'd0;
            index_reg   <= 10'd0;
        end else begin
            if (advance) begin
                phase_reg   <= phase_next;
                crc_reg     <= crc_next;
                pos_reg     <= pos_next;
                type_reg    <= type_next;
                length_reg  <= length_next;
                stamp_reg   <= stamp_next;
                frame_reg   <= frame_next;
                crc_low_reg <= crc_low_next;
                good_reg    <= good_next;
                crc_err_reg <= crc_err_next;
                desync_reg  <= desync_next;
                kind_reg    <= kind_next;
                data_reg    <= data_next;
                index_reg   <= index_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = kind_reg;
    assign m_data_byte       = data_reg;
    assign m_payload_index   = index_reg;
    assign m_packet_type     = type_reg;
    assign m_packet_length   = length_reg;
    assign m_time_stamp      = stamp_reg;
    assign m_frame_number    = frame_reg;
    assign m_good_count      = good_reg;
    assign m_crc_error_count = crc_err_reg;
    assign m_desync_count    = desync_reg;

endmodule

// File: hdl/fppc_checker.sv
// Port-level checker for the packet deframer and its bind to the top level.
`include "framed_packet_parser_crc16_core_assert.svh"

module fppc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [7:0]  m_data_byte,
    input logic [9:0]  m_payload_index,
    input logic [10:0] m_packet_length
);
    import fppc_pkg::*;

    // A result that is not taken keeps its kind and byte.
    `FPPC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_data_byte), "result changed while stalled")

    `FPPC_ASSERT_NEXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_valid, "result valid straight after reset")

    // Only forwarded payload bytes carry a byte and a position.
    `FPPC_ASSERT_NOW(a_idle_fields_zero, aclk, aresetn, m_valid && m_kind != KIND_PAYLOAD, m_data_byte == 8'd0 && m_payload_index == 10'd0, "non-payload result carries data")

    `FPPC_ASSERT_NOW(a_index_in_packet, aclk, aresetn, m_valid && m_kind == KIND_PAYLOAD, 11'(m_payload_index) < m_packet_length, "payload index beyond packet length")

endmodule

bind framed_packet_parser_crc16_core fppc_checker u_fppc_checker (.*);
